// ----- design/sfms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfms_pkg
// Shared types and constants of the first-match substring search.
// ----------------------------------------------------------------------------
package sfms_pkg;

   localparam int NEEDLE_MAX  = 64;
   localparam int COUNT_W     = $clog2(NEEDLE_MAX + 1);
   localparam int CHAR_W      = 8;
   localparam int POS_W       = 32;
   localparam int STATUS_W    = 2;

   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_NEEDLE = 2'd1,
      CMD_HAY    = 2'd2,
      CMD_FINISH = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   // Control broadcast to every cell of the chain
   typedef struct packed {
      logic              clear;
      logic              load;
      logic              shift;
      logic [CHAR_W-1:0] char_value;
   } cell_ctrl_type;

endpackage

// ----- design/sfms_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfms_req_if / sfms_rsp_if
// Valid/ready channels carrying search commands and search results.
// ----------------------------------------------------------------------------
interface sfms_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    cmd;
   logic [sfms_pkg::CHAR_W-1:0]   char_value;

   modport source (output valid, output cmd, output char_value, input ready);
   modport sink   (input valid, input cmd, input char_value, output ready);
endinterface

interface sfms_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sfms_pkg::POS_W-1:0]    position;
   logic [sfms_pkg::STATUS_W-1:0] status;

   modport source (output valid, output position, output status, input ready);
   modport sink   (input valid, input position, input status, output ready);
endinterface

// ----- design/sfms_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfms_cell
// One needle character slot with its partial-match bit.
// ----------------------------------------------------------------------------
module sfms_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  sfms_pkg::cell_ctrl_type     ctrl,
   input  logic [sfms_pkg::CHAR_W-1:0] needle_in,
   input  logic                        used_in,
   input  logic                        used_up,
   input  logic                        match_up,
   output logic [sfms_pkg::CHAR_W-1:0] needle_out,
   output logic                        used_out,
   output logic                        match_out
);

   logic [sfms_pkg::CHAR_W-1:0] needle_ff;
   logic                        used_ff;
   logic                        match_ff;
   logic                        match_in;

   // extend the partial match from the neighbor above, or start one here
   assign match_in = used_ff & (used_up ? match_up : 1'b1)
                     & (needle_ff == ctrl.char_value);

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         needle_ff <= needle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         used_ff  <= 1'b0;
         match_ff <= 1'b0;
      end else if (ctrl.load) begin
         used_ff  <= used_in;
      end else if (ctrl.shift) begin
         match_ff <= match_in;
      end
   end

   assign needle_out = needle_ff;
   assign used_out   = used_ff;
   assign match_out  = match_ff;

endmodule

// ----- design/sfms_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfms_chain
// Row of needle cells; needle shifts up on load, match bits flow down.
// ----------------------------------------------------------------------------
module sfms_chain (
   input  logic                    clock,
   input  logic                    reset,
   input  sfms_pkg::cell_ctrl_type ctrl,
   output logic                    full_match
);

   localparam int N = sfms_pkg::NEEDLE_MAX;

   logic [sfms_pkg::CHAR_W-1:0] needle_w [N];
   logic [N-1:0]                used_w;
   logic [N-1:0]                match_w;

   for (genvar j = 0; j < N; j++) begin : g_cell
      logic [sfms_pkg::CHAR_W-1:0] needle_lo;
      logic                        used_lo;
      logic                        used_hi;
      logic                        match_hi;

      if (j == 0) begin : g_bottom
         assign needle_lo = ctrl.char_value;
         assign used_lo   = 1'b1;
      end else begin : g_mid_lo
         assign needle_lo = needle_w[j-1];
         assign used_lo   = used_w[j-1];
      end

      if (j == N - 1) begin : g_top
         assign used_hi  = 1'b0;
         assign match_hi = 1'b0;
      end else begin : g_mid_hi
         assign used_hi  = used_w[j+1];
         assign match_hi = match_w[j+1];
      end

      sfms_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .needle_in  (needle_lo),
         .used_in    (used_lo),
         .used_up    (used_hi),
         .match_up   (match_hi),
         .needle_out (needle_w[j]),
         .used_out   (used_w[j]),
         .match_out  (match_w[j])
      );
   end

   assign full_match = match_w[0];

endmodule

// ----- design/substring_first_match_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_first_match_search
// First-occurrence substring search over a streamed haystack.
// ----------------------------------------------------------------------------
// Command beats may follow back to back. The needle (up to NEEDLE_MAX
// characters) shifts into a chain of cells, one character per cell; each
// haystack beat moves the partial-match bits one cell down the chain, so a
// full match shows at the bottom cell in the cycle after the beat whose
// character completes it, and its position is latched in the cycle after
// that. A finish beat returns position and status through an output register;
// the request side stalls only while that register holds an untaken result.
// ----------------------------------------------------------------------------
module substring_first_match_search (
   input  logic       clock,
   input  logic       reset,
   sfms_req_if.sink   req_chan,
   sfms_rsp_if.source rsp_chan
);

   localparam logic [sfms_pkg::POS_W-1:0] COUNT_MAX = '1;
   localparam logic [sfms_pkg::COUNT_W-1:0] NEEDLE_FULL =
      sfms_pkg::COUNT_W'(sfms_pkg::NEEDLE_MAX);

   logic [sfms_pkg::COUNT_W-1:0]  needle_count_ff, needle_count_in;
   logic [sfms_pkg::POS_W-1:0]    hay_count_ff, hay_count_in;
   logic [sfms_pkg::POS_W-1:0]    match_pos_ff, match_pos_in;
   logic                          found_ff, found_in;
   logic                          overflow_ff, overflow_in;
   logic                          saturated_ff, saturated_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sfms_pkg::POS_W-1:0]    rsp_position_ff, rsp_position_in;
   logic [sfms_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                          beat;
   logic                          is_start, is_needle, is_hay, is_finish;
   logic                          hay_take;
   logic                          full_match;
   logic                          found_now;
   logic [sfms_pkg::POS_W-1:0]    chain_pos;
   logic [sfms_pkg::POS_W-1:0]    pos_now;
   sfms_pkg::cell_ctrl_type       ctrl;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign beat      = req_chan.valid && req_chan.ready;
   assign is_start  = beat && (req_chan.cmd == sfms_pkg::CMD_START);
   assign is_needle = beat && (req_chan.cmd == sfms_pkg::CMD_NEEDLE);
   assign is_hay    = beat && (req_chan.cmd == sfms_pkg::CMD_HAY);
   assign is_finish = beat && (req_chan.cmd == sfms_pkg::CMD_FINISH);
   assign hay_take  = is_hay && !saturated_ff && (hay_count_ff != COUNT_MAX);

   assign ctrl.clear      = is_start;
   assign ctrl.load       = is_needle && (hay_count_ff == '0) && !saturated_ff
                            && (needle_count_ff != NEEDLE_FULL);
   assign ctrl.shift      = hay_take;
   assign ctrl.char_value = req_chan.char_value;

   sfms_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .full_match (full_match)
   );

   assign chain_pos = hay_count_ff - sfms_pkg::POS_W'(needle_count_ff)
                      + sfms_pkg::POS_W'(1);
   assign found_now = found_ff || full_match;
   assign pos_now   = found_ff ? match_pos_ff : chain_pos;

   always_comb begin
      needle_count_in = needle_count_ff;
      hay_count_in    = hay_count_ff;
      match_pos_in    = match_pos_ff;
      found_in        = found_ff;
      overflow_in     = overflow_ff;
      saturated_in    = saturated_ff;
      if (is_start) begin
         needle_count_in = '0;
         hay_count_in    = '0;
         match_pos_in    = '0;
         found_in        = 1'b0;
         overflow_in     = 1'b0;
         saturated_in    = 1'b0;
      end else begin
         // latch a match completed by the previous haystack beat
         if (full_match && !found_ff) begin
            found_in     = 1'b1;
            match_pos_in = chain_pos;
         end
         if (ctrl.load) begin
            needle_count_in = needle_count_ff + sfms_pkg::COUNT_W'(1);
         end
         if (is_needle && (hay_count_ff == '0) && !saturated_ff
             && (needle_count_ff == NEEDLE_FULL)) begin
            overflow_in = 1'b1;
         end
         if (is_hay && !hay_take) begin
            saturated_in = 1'b1;
         end
         if (hay_take) begin
            hay_count_in = hay_count_ff + sfms_pkg::POS_W'(1);
            if (!found_ff && (needle_count_ff == '0)) begin
               found_in     = 1'b1;
               match_pos_in = sfms_pkg::POS_W'(1);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_position_in = rsp_position_ff;
      rsp_status_in   = rsp_status_ff;
      if (is_finish) begin
         rsp_valid_in = 1'b1;
         if (overflow_ff) begin
            rsp_position_in = '0;
            rsp_status_in   = sfms_pkg::STATUS_OVERFLOW;
         end else begin
            rsp_position_in = found_now ? pos_now : '0;
            rsp_status_in   = saturated_ff ? sfms_pkg::STATUS_SATURATED
                                           : sfms_pkg::STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_count_ff <= '0;
         hay_count_ff    <= '0;
         match_pos_ff    <= '0;
         found_ff        <= 1'b0;
         overflow_ff     <= 1'b0;
         saturated_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         needle_count_ff <= needle_count_in;
         hay_count_ff    <= hay_count_in;
         match_pos_ff    <= match_pos_in;
         found_ff        <= found_in;
         overflow_ff     <= overflow_in;
         saturated_ff    <= saturated_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_position_ff <= rsp_position_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.position = rsp_position_ff;
   assign rsp_chan.status   = rsp_status_ff;

endmodule
